/* src/mvf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvf_pkg
// Shared types and constants of the mother vertex finder.
// ----------------------------------------------------------------------------
package mvf_pkg;

  localparam int unsigned MaxVerticesDef = 16;
  localparam int unsigned VcW            = 5;
  localparam int unsigned VertexInW      = 4;
  localparam int unsigned MotherW        = 4;
  localparam int unsigned ModeW          = 2;
  localparam int unsigned InDataW        = 8;
  localparam int unsigned OutDataW       = 8;
  localparam logic [VcW-1:0] VcReset     = 5'd16;

  typedef enum logic [ModeW-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_FIND  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_ROOT,
    ST_PASS2,
    ST_READ,
    ST_EVAL,
    ST_POP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;       // latch edge fields of the accepted request
    logic adj_clear;     // drop every adjacency row
    logic adj_addr_top;  // adjacency read at top of stack, else at request source
    logic edge_write;    // write back the row with the new edge
    logic find_init;     // clear visited marks for the first pass
    logic root_start;    // open a new tree at the lowest unvisited vertex
    logic cand_start;    // open the check pass at the candidate
    logic step;          // one push or pop of the depth-first walk
    logic pop_load;      // load top from the stack read data
    logic out_load;      // load the result register
  } cmd_t;

  typedef struct packed {
    logic root_avail;    // an unvisited vertex is left
    logic open_any;      // top of stack has an unvisited neighbor
    logic depth_one;     // only the root is on the stack
    logic out_free;      // result register can take a new result
  } sts_t;

endpackage

/* src/mvf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvf_ctrl
// Sequencer for request handling and the two depth-first passes.
// ----------------------------------------------------------------------------
module mvf_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [mvf_pkg::ModeW-1:0]   in_mode_i,
  output logic                        in_ready_o,
  input  mvf_pkg::sts_t               sts_i,
  output mvf_pkg::cmd_t               cmd_o
);

  mvf_pkg::state_e state_q, state_d;
  logic            pass2_q, pass2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvf_pkg::ST_IDLE;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass2_q <= pass2_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pass2_d    = pass2_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mvf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_mode_i == mvf_pkg::MODE_CLEAR) begin
            cmd_o.adj_clear = 1'b1;
          end else if (in_mode_i == mvf_pkg::MODE_ADD) begin
            state_d = mvf_pkg::ST_EDGE;
          end else if (in_mode_i == mvf_pkg::MODE_FIND) begin
            cmd_o.find_init = 1'b1;
            pass2_d         = 1'b0;
            state_d         = mvf_pkg::ST_ROOT;
          end
        end
      end
      mvf_pkg::ST_EDGE: begin
        cmd_o.edge_write = 1'b1;
        state_d          = mvf_pkg::ST_IDLE;
      end
      mvf_pkg::ST_ROOT: begin
        if (sts_i.root_avail) begin
          cmd_o.root_start = 1'b1;
          state_d          = mvf_pkg::ST_READ;
        end else begin
          state_d = mvf_pkg::ST_PASS2;
        end
      end
      mvf_pkg::ST_PASS2: begin
        cmd_o.cand_start = 1'b1;
        pass2_d          = 1'b1;
        state_d          = mvf_pkg::ST_READ;
      end
      mvf_pkg::ST_READ: begin
        cmd_o.adj_addr_top = 1'b1;
        state_d            = mvf_pkg::ST_EVAL;
      end
      mvf_pkg::ST_EVAL: begin
        cmd_o.step = 1'b1;
        if (sts_i.open_any) begin
          state_d = mvf_pkg::ST_READ;
        end else if (sts_i.depth_one) begin
          state_d = pass2_q ? mvf_pkg::ST_DONE : mvf_pkg::ST_ROOT;
        end else begin
          state_d = mvf_pkg::ST_POP;
        end
      end
      mvf_pkg::ST_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = mvf_pkg::ST_READ;
      end
      mvf_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mvf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mvf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/mvf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvf_dp
// Adjacency memory, visited marks, traversal stack and result register.
// ----------------------------------------------------------------------------
module mvf_dp #(
  parameter int unsigned MAX_VERTICES = mvf_pkg::MaxVerticesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mvf_pkg::VcW-1:0]       cfg_wdata_i,
  input  logic [mvf_pkg::VertexInW-1:0] in_from_i,
  input  logic [mvf_pkg::VertexInW-1:0] in_to_i,
  input  mvf_pkg::cmd_t                 cmd_i,
  output mvf_pkg::sts_t                 sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_found_o,
  output logic [mvf_pkg::MotherW-1:0]   out_mother_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IW = mvf_pkg::VertexInW;

  // configuration
  logic [mvf_pkg::VcW-1:0] vc_q;
  logic [CW-1:0]           n_eff;
  logic [CW+mvf_pkg::VcW-1:0] vc_ext;
  logic [MAX_VERTICES-1:0] mask;

  // request fields
  logic [IW-1:0] from_q, to_q;
  logic [VW+IW-1:0] from_wide, in_from_wide;
  logic [VW-1:0]    from_idx, in_from_idx;
  logic             edge_ok;
  logic [MAX_VERTICES-1:0] to_onehot;

  // adjacency memory with one valid bit per row
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_vld_q;
  logic [MAX_VERTICES-1:0] adj_rdata_q;
  logic                    adj_rvld_q;
  logic [VW-1:0]           adj_raddr;
  logic [MAX_VERTICES-1:0] row;

  // walk state
  logic [MAX_VERTICES-1:0] visited_q;
  logic [VW-1:0]           top_q, cand_q;
  logic [CW-1:0]           depth_q;
  logic [CW-1:0]           depth_m2;
  logic [VW-1:0]           stk_mem [MAX_VERTICES];
  logic [VW-1:0]           stk_rdata_q;
  logic                    stk_we;
  logic [VW-1:0]           stk_waddr, stk_wdata;
  logic                    push_room;
  logic [MAX_VERTICES-1:0] cand_onehot;

  // lowest set bit unit, shared by root search and neighbor search
  logic [MAX_VERTICES-1:0] srch_vec, srch_low;
  logic [VW-1:0]           srch_idx;

  // result
  logic                  out_valid_q, found_q;
  logic [mvf_pkg::MotherW-1:0] mother_q;
  logic [VW+mvf_pkg::MotherW-1:0] cand_wide;
  logic                  all_reached;

  // effective vertex count: zero counts as one, saturate at the array size
  assign vc_ext = {{CW{1'b0}}, vc_q};
  always_comb begin
    if (vc_q == '0) begin
      n_eff = CW'(1);
    end else if (vc_ext > (CW + mvf_pkg::VcW)'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = vc_ext[CW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = (n_eff > CW'(i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= mvf_pkg::VcReset;
    end else if (cfg_we_i) begin
      vc_q <= cfg_wdata_i;
    end
  end

  // request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      from_q <= in_from_i;
      to_q   <= in_to_i;
    end
  end

  assign from_wide    = {{VW{1'b0}}, from_q};
  assign in_from_wide = {{VW{1'b0}}, in_from_i};
  assign from_idx     = from_wide[VW-1:0];
  assign in_from_idx  = in_from_wide[VW-1:0];
  assign edge_ok      = ({{CW{1'b0}}, from_q} < {{IW{1'b0}}, n_eff}) &&
                        ({{CW{1'b0}}, to_q} < {{IW{1'b0}}, n_eff});

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      to_onehot[i]   = ({{CW{1'b0}}, to_q} == (CW + IW)'(i));
      cand_onehot[i] = (cand_q == VW'(i));
    end
  end

  // adjacency memory
  assign adj_raddr = cmd_i.adj_addr_top ? top_q : in_from_idx;
  assign row       = adj_rvld_q ? adj_rdata_q : '0;

  always_ff @(posedge clk_i) begin
    adj_rdata_q <= adj_mem[adj_raddr];
    if (cmd_i.edge_write && edge_ok) begin
      adj_mem[from_idx] <= row | to_onehot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q  <= '0;
      adj_rvld_q <= 1'b0;
    end else begin
      adj_rvld_q <= adj_vld_q[adj_raddr];
      if (cmd_i.adj_clear) begin
        adj_vld_q <= '0;
      end else if (cmd_i.edge_write && edge_ok) begin
        adj_vld_q[from_idx] <= 1'b1;
      end
    end
  end

  // lowest set bit: isolate with a two's complement, then encode
  assign srch_vec = cmd_i.step ? (row & mask & ~visited_q) : (mask & ~visited_q);
  assign srch_low = srch_vec & (~srch_vec + MAX_VERTICES'(1));
  always_comb begin
    srch_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      srch_idx = srch_idx | (srch_low[i] ? VW'(i) : '0);
    end
  end

  // traversal stack
  assign push_room = (depth_q < CW'(MAX_VERTICES));
  assign depth_m2  = depth_q - CW'(2);

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = srch_idx;
    if (cmd_i.root_start) begin
      stk_we = 1'b1;
    end else if (cmd_i.cand_start) begin
      stk_we    = 1'b1;
      stk_wdata = cand_q;
    end else if (cmd_i.step && (srch_vec != '0) && push_room) begin
      stk_we    = 1'b1;
      stk_waddr = depth_q[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    stk_rdata_q <= stk_mem[depth_m2[VW-1:0]];
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      depth_q   <= '0;
      top_q     <= '0;
      cand_q    <= '0;
    end else begin
      if (cmd_i.find_init) begin
        visited_q <= '0;
        cand_q    <= '0;
      end else if (cmd_i.root_start) begin
        visited_q <= visited_q | srch_low;
        top_q     <= srch_idx;
        cand_q    <= srch_idx;
        depth_q   <= CW'(1);
      end else if (cmd_i.cand_start) begin
        visited_q <= cand_onehot;
        top_q     <= cand_q;
        depth_q   <= CW'(1);
      end else if (cmd_i.step) begin
        if (srch_vec != '0) begin
          visited_q <= visited_q | srch_low;
          if (push_room) begin
            top_q   <= srch_idx;
            depth_q <= depth_q + CW'(1);
          end
        end else begin
          depth_q <= depth_q - CW'(1);
        end
      end else if (cmd_i.pop_load) begin
        top_q <= stk_rdata_q;
      end
    end
  end

  // result register
  assign all_reached = ((visited_q & mask) == mask);
  assign cand_wide   = {{mvf_pkg::MotherW{1'b0}}, cand_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_q  <= all_reached;
      mother_q <= all_reached ? cand_wide[mvf_pkg::MotherW-1:0] : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_found_o  = found_q;
  assign out_mother_o = mother_q;

  assign sts_o.root_avail = ((mask & ~visited_q) != '0);
  assign sts_o.open_any   = (srch_vec != '0);
  assign sts_o.depth_one  = (depth_q == CW'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

/* src/mother_vertex_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mother_vertex_finder
// Keeps a directed graph as an adjacency bit matrix and finds a mother vertex
// with two depth-first passes driven by an explicit stack.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tuser: mode[1:0]; tdata: edge_from[3:0], edge_to[7:4]
//  m_axis    out        tuser: found; tdata: mother[3:0], zeros above
//  cfg       in         cfg_wdata_i: vertex_count[4:0]
//
// clear acts on the accepted request at once; add edge reads the row, then writes it back.
// during find, each step of the walk waits on the registered read of the
// adjacency row and, on a pop, on the registered read of the stack.
// reset empties the graph at once through per-row valid bits.
// a finished result waits in the output register; a find that ends while it
// is still held stalls there, and no new request is taken meanwhile.
module mother_vertex_finder #(
  parameter int unsigned MAX_VERTICES = mvf_pkg::MaxVerticesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mvf_pkg::VcW-1:0]       cfg_wdata_i,    // vertex_count
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mvf_pkg::InDataW-1:0]   s_axis_tdata,   // edge_from, edge_to
  input  logic [mvf_pkg::ModeW-1:0]     s_axis_tuser,   // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mvf_pkg::OutDataW-1:0]  m_axis_tdata,   // mother
  output logic                          m_axis_tuser    // found
);

  mvf_pkg::cmd_t               cmd;
  mvf_pkg::sts_t               sts;
  logic [mvf_pkg::MotherW-1:0] mother;

  mvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mvf_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_from_i    (s_axis_tdata[3:0]),
    .in_to_i      (s_axis_tdata[7:4]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_found_o  (m_axis_tuser),
    .out_mother_o (mother)
  );

  assign m_axis_tdata = {{(mvf_pkg::OutDataW - mvf_pkg::MotherW){1'b0}}, mother};

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mother vertex finder. Graph build and find
// requests go in through the input stream; every find answer is checked
// against an in-bench graph model. Vertex counts are changed between phases
// while the block is idle, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [mvf_pkg::ModeW-1:0] ModeSpare = 2'd3;
  localparam int unsigned PauseCycles   = 200;   // beyond the slowest find
  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned PhaseItems    = 65;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned PressurePhase = 4;

  typedef struct packed {
    logic [mvf_pkg::ModeW-1:0] mode;
    logic [3:0]                dst;
    logic [3:0]                src;
  } request_t;

  typedef struct packed {
    logic                        found;
    logic [mvf_pkg::MotherW-1:0] mother;
  } answer_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [mvf_pkg::VcW-1:0]      cfg_wdata_i   = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [mvf_pkg::InDataW-1:0]  s_axis_tdata  = '0;   // edge_from[3:0], edge_to[7:4]
  logic [mvf_pkg::ModeW-1:0]    s_axis_tuser  = '0;   // mode
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [mvf_pkg::OutDataW-1:0] m_axis_tdata;         // mother[3:0], zeros above
  logic                         m_axis_tuser;         // found

  // graph model and bench bookkeeping
  logic [15:0]             graph_rows [16];
  logic [mvf_pkg::VcW-1:0] vertex_limit;
  request_t                pending_requests [$];
  answer_t                 expected_answers [$];
  int unsigned             send_idle_pct  = 0;
  int unsigned             sink_stall_pct = 0;
  logic                    hold_off       = 1'b0;
  int unsigned             quiet_cycles   = 0;
  int unsigned             mismatches     = 0;
  int unsigned             accepted_items = 0;
  int unsigned             finds_checked  = 0;
  int unsigned             mothers_seen   = 0;

  mother_vertex_finder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned active_vertices(input logic [mvf_pkg::VcW-1:0] count);
    if (count == 0) return 1;
    if (count > 16) return 16;
    return count;
  endfunction

  // depth-first walk from root, lowest neighbor first; returns the grown mark set
  function automatic logic [15:0] reach_set(input logic [3:0] root, input logic [15:0] mask,
                                            input logic [15:0] seen);
    logic [3:0]  path [16];
    int          depth;
    int          w;
    logic [15:0] open_set;
    seen[root] = 1'b1;
    path[0]    = root;
    depth      = 1;
    while (depth > 0) begin
      open_set = graph_rows[path[depth-1]] & mask & ~seen;
      if (open_set != 0) begin
        w = 0;
        while (!open_set[w]) w++;
        seen[w] = 1'b1;
        if (depth < 16) begin
          path[depth] = w[3:0];
          depth++;
        end
      end else begin
        depth--;
      end
    end
    return seen;
  endfunction

  function automatic answer_t find_mother();
    int unsigned n;
    logic [15:0] mask;
    logic [15:0] seen;
    logic [3:0]  cand;
    answer_t     ans;
    n    = active_vertices(vertex_limit);
    mask = (n == 16) ? 16'hFFFF : 16'((32'd1 << n) - 1);
    seen = '0;
    cand = '0;
    // the root of the last tree is the only possible mother
    for (int i = 0; i < n; i++) begin
      if (!seen[i]) begin
        cand = i[3:0];
        seen = reach_set(cand, mask, seen);
      end
    end
    seen       = reach_set(cand, mask, 16'h0);
    ans.found  = ((seen & mask) == mask);
    ans.mother = ans.found ? cand : '0;
    return ans;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  // sender
  always @(posedge clk_i) begin : driver
    request_t req;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.mode;
        s_axis_tdata  <= {req.dst, req.src};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // predict on each accepted request, check each delivered answer
  always @(posedge clk_i) begin : monitor
    request_t    req;
    answer_t     want;
    int unsigned n;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req = '{mode: s_axis_tuser, dst: s_axis_tdata[7:4], src: s_axis_tdata[3:0]};
        n   = active_vertices(vertex_limit);
        accepted_items++;
        case (req.mode)
          mvf_pkg::MODE_CLEAR: begin
            foreach (graph_rows[i]) graph_rows[i] = '0;
          end
          mvf_pkg::MODE_ADD: begin
            if (req.src < n && req.dst < n) graph_rows[req.src][req.dst] = 1'b1;
          end
          mvf_pkg::MODE_FIND: begin
            want             = find_mother();
            expected_answers = {expected_answers, want};
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_answers.size() == 0) begin
          flag_mismatch("answer with no find pending", m_axis_tdata, 0);
        end else begin
          want = expected_answers.pop_front();
          finds_checked++;
          if (want.found) mothers_seen++;
          if (m_axis_tuser !== want.found) begin
            flag_mismatch("found", m_axis_tuser, want.found);
          end
          if (m_axis_tdata !== {4'h0, want.mother}) begin
            flag_mismatch("mother", m_axis_tdata, want.mother);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("watchdog: no request or answer moved for %0d cycles", StallLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_request(input logic [mvf_pkg::ModeW-1:0] mode, input int src,
                             input int dst);
    request_t r;
    r = '{mode: mode, dst: dst[3:0], src: src[3:0]};
    pending_requests = {pending_requests, r};
  endtask

  // wait until every request went in and every answer came out, then let a find finish
  task automatic drain_block();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_answers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PauseCycles) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[mvf_pkg::VcW-1:0];
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    vertex_limit = value[mvf_pkg::VcW-1:0];
  endtask

  // one graph build followed by a find
  task automatic add_round(input int unsigned n);
    int order [16];
    int tmp;
    int j;
    int unsigned shape;
    if ($urandom_range(9) < 7) begin
      add_request(mvf_pkg::MODE_CLEAR, $urandom_range(15), $urandom_range(15));
    end
    shape = $urandom_range(3);
    if (shape <= 1) begin
      // spanning tree from a random root, sometimes with a missing branch
      for (int i = 0; i < 16; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int k = 1; k < n; k++) begin
        if ($urandom_range(19) != 0) begin
          add_request(mvf_pkg::MODE_ADD, order[$urandom_range(k - 1)], order[k]);
        end
      end
      repeat ($urandom_range(3)) begin
        add_request(mvf_pkg::MODE_ADD, $urandom_range(n - 1), $urandom_range(n - 1));
      end
    end else if (shape == 2) begin
      repeat ($urandom_range(2 * n)) begin
        add_request(mvf_pkg::MODE_ADD, $urandom_range(n - 1), $urandom_range(n - 1));
      end
    end else begin
      // noise: any vertex numbers, spare mode, stray finds
      repeat ($urandom_range(8, 2)) begin
        case ($urandom_range(5))
          0:       add_request(ModeSpare, $urandom_range(15), $urandom_range(15));
          1:       add_request(mvf_pkg::MODE_FIND, $urandom_range(15), $urandom_range(15));
          default: add_request(mvf_pkg::MODE_ADD, $urandom_range(15), $urandom_range(15));
        endcase
      end
    end
    add_request(mvf_pkg::MODE_FIND, $urandom_range(15), $urandom_range(15));
  endtask

  initial begin : stimulus
    int vc_plan [NumPhases];
    int start_items;
    int unsigned n;
    vc_plan = '{16, 31, 0, 1, 2, 8, 5, 17, 12, 16};
    foreach (graph_rows[i]) graph_rows[i] = '0;
    vertex_limit = mvf_pkg::VcReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty graph, field extremes, self loops and the spare mode at full size
    add_request(mvf_pkg::MODE_FIND, 15, 15);
    add_request(mvf_pkg::MODE_ADD, 0, 15);
    add_request(mvf_pkg::MODE_ADD, 15, 0);
    add_request(mvf_pkg::MODE_ADD, 15, 15);
    add_request(mvf_pkg::MODE_ADD, 0, 0);
    add_request(ModeSpare, 15, 15);
    add_request(ModeSpare, 0, 0);
    add_request(mvf_pkg::MODE_FIND, 0, 0);
    add_request(mvf_pkg::MODE_CLEAR, 15, 15);
    add_request(mvf_pkg::MODE_FIND, 0, 0);
    drain_block();

    // four vertices: chain from 3, edges past the count are dropped
    write_vertex_count(4);
    add_request(mvf_pkg::MODE_ADD, 3, 0);
    add_request(mvf_pkg::MODE_ADD, 0, 1);
    add_request(mvf_pkg::MODE_ADD, 1, 2);
    add_request(mvf_pkg::MODE_ADD, 3, 9);
    add_request(mvf_pkg::MODE_ADD, 9, 1);
    add_request(mvf_pkg::MODE_FIND, 0, 0);
    drain_block();
    // single vertex, zero count taken as one, oversize count saturated
    write_vertex_count(1);
    add_request(mvf_pkg::MODE_FIND, 0, 0);
    drain_block();
    write_vertex_count(0);
    add_request(mvf_pkg::MODE_ADD, 0, 0);
    add_request(mvf_pkg::MODE_FIND, 0, 0);
    drain_block();
    write_vertex_count(31);
    add_request(mvf_pkg::MODE_FIND, 0, 0);
    drain_block();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) vc_plan[p] = $urandom_range(31);
      write_vertex_count(vc_plan[p]);
      n = active_vertices(vc_plan[p]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin send_idle_pct = 83; sink_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  sink_stall_pct = 83; end
        default: begin send_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      start_items = pending_requests.size();
      if (p == PressurePhase) begin
        // answers back up while finds keep coming, so the input has to stall
        fork
          begin
            hold_off <= 1'b1;
            repeat (HoldOffCycles) @(posedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
        repeat (25) add_request(mvf_pkg::MODE_FIND, $urandom_range(15), $urandom_range(15));
      end
      while (pending_requests.size() - start_items < PhaseItems) add_round(n);
      drain_block();
    end

    $display("covered %0d requests over %0d vertex count settings", accepted_items,
             NumPhases + 5);
    $display("checked %0d find answers, %0d with a mother vertex", finds_checked, mothers_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mvf_pkg.sv
src/mvf_ctrl.sv
src/mvf_dp.sv
src/mother_vertex_finder.sv
dv/testbench.sv
